[rtl/bdf_pkg.sv]
// ----------------------------------------------------------------------------
// bdf_pkg
// types, board masks and shift helpers for the directional bitboard fill
// ----------------------------------------------------------------------------
package bdf_pkg;

  // compass directions, bit index = 8 * rank + file
  typedef enum logic [2:0] {
    DIR_N  = 3'd0,
    DIR_NE = 3'd1,
    DIR_E  = 3'd2,
    DIR_SE = 3'd3,
    DIR_S  = 3'd4,
    DIR_SW = 3'd5,
    DIR_W  = 3'd6,
    DIR_NW = 3'd7
  } dir_e;

  // query modes
  localparam logic MODE_FILL = 1'b0;
  localparam logic MODE_SPAN = 1'b1;

  typedef logic [63:0] board_t;

  localparam board_t FILE_A_MASK = 64'h0101_0101_0101_0101;
  localparam board_t FILE_H_MASK = 64'h8080_8080_8080_8080;
  localparam board_t ALL_SQUARES = 64'hFFFF_FFFF_FFFF_FFFF;

  // one step distances
  localparam int unsigned STEP_RANK = 8;
  localparam int unsigned STEP_DIAG = 9;
  localparam int unsigned STEP_ANTI = 7;
  localparam int unsigned STEP_FILE = 1;

  // squares a step may land on, clears the file the board would wrap onto
  function automatic board_t dir_keep(dir_e d);
    board_t k;
    case (d)
      DIR_N, DIR_S:                 k = ALL_SQUARES;
      DIR_NE, DIR_E, DIR_SE:        k = ~FILE_A_MASK;
      DIR_SW, DIR_W, DIR_NW:        k = ~FILE_H_MASK;
      default:                      k = ALL_SQUARES;
    endcase
    return k;
  endfunction

  // move a board by a fixed number of steps in a direction
  function automatic board_t move_by(board_t x, dir_e d, int unsigned times);
    board_t r;
    case (d)
      DIR_N:   r = x << (STEP_RANK * times);
      DIR_NE:  r = x << (STEP_DIAG * times);
      DIR_E:   r = x << (STEP_FILE * times);
      DIR_SE:  r = x >> (STEP_ANTI * times);
      DIR_S:   r = x >> (STEP_RANK * times);
      DIR_SW:  r = x >> (STEP_DIAG * times);
      DIR_W:   r = x >> (STEP_FILE * times);
      DIR_NW:  r = x << (STEP_ANTI * times);
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

[rtl/bitboard_directional_fill.sv]
// ----------------------------------------------------------------------------
// bitboard_directional_fill
// occluded fill or span of a generator bitboard in one compass direction
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_axis   in   tvalid / tready     tdata 128 b, tuser 4 b
//  m_axis   out  tvalid / tready     tdata 64 b
//
//  one item per cycle sustained while m_axis is not stalled; a result is
//  offered after input register, fill network and result register
//  rst_ni clears both valid flags asynchronously; payload holds no reset
//  a stalled result holds in the result register while the input register
//  still takes one more item; s_axis_tready_o drops only when both are full
// ----------------------------------------------------------------------------
module bitboard_directional_fill import bdf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // generators [63:0], propagators [127:64]
  input  logic [3:0]   s_axis_tuser_i,   // mode [0], direction [3:1]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o    // filled_board [63:0]
);

  logic   in_valid_q;
  logic   mode_q;
  dir_e   dir_q;
  board_t gen_q, pro_q;
  logic   out_valid_q;
  board_t res_q, res_d;
  logic   out_ready, in_ready;
  board_t fill_occ, fill_all;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign in_ready  = !in_valid_q || out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      mode_q <= s_axis_tuser_i[0];
      dir_q  <= dir_e'(s_axis_tuser_i[3:1]);
      gen_q  <= s_axis_tdata_i[63:0];
      pro_q  <= s_axis_tdata_i[127:64];
    end
  end

  // fill through the propagators
  bdf_fill u_fill_occ (
    .dir_i  (dir_q),
    .gen_i  (gen_q),
    .pro_i  (pro_q),
    .fill_o (fill_occ)
  );

  // unblocked fill for span mode
  bdf_fill u_fill_all (
    .dir_i  (dir_q),
    .gen_i  (gen_q),
    .pro_i  (ALL_SQUARES),
    .fill_o (fill_all)
  );

  // span drops the generators by one more step past the unblocked fill
  always_comb begin
    if (mode_q == MODE_SPAN) begin
      res_d = move_by(fill_all, dir_q, 1) & dir_keep(dir_q);
    end else begin
      res_d = fill_occ;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

endmodule

[rtl/bdf_fill.sv]
// ----------------------------------------------------------------------------
// bdf_fill
// three-level kogge-stone occluded fill, steps of one, two and four squares
// ----------------------------------------------------------------------------
module bdf_fill import bdf_pkg::*; (
  input  dir_e   dir_i,
  input  board_t gen_i,
  input  board_t pro_i,
  output board_t fill_o
);

  board_t pro0, pro1, pro2;
  board_t gen1, gen2, gen3;

  // wrap guard on the propagators, then three prefix levels
  always_comb begin
    pro0 = pro_i & dir_keep(dir_i);
    gen1 = gen_i | (pro0 & move_by(gen_i, dir_i, 1));
    pro1 = pro0 & move_by(pro0, dir_i, 1);
    gen2 = gen1 | (pro1 & move_by(gen1, dir_i, 2));
    pro2 = pro1 & move_by(pro1, dir_i, 2);
    gen3 = gen2 | (pro2 & move_by(gen2, dir_i, 4));
  end

  assign fill_o = gen3;

endmodule

[rtl/bdf_checker.sv]
// ----------------------------------------------------------------------------
// bdf_checker
// port-level checks on the directional fill over time
// ----------------------------------------------------------------------------
module bdf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // with no result pending the input side is always open
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty result register");

  // a fresh result comes from an item taken earlier, held in the input register, then the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a matching item");

endmodule

bind bitboard_directional_fill bdf_checker u_bdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[tb/bdf_fill_checker.sv]
// ----------------------------------------------------------------------------
// bdf_fill_checker
// watches both streams of the directional fill, predicts and compares boards
// ----------------------------------------------------------------------------
// Every item taken on the input stream is run through a local model of the
// Kogge-Stone occluded fill and the span. The model uses shifts of 1, 2 and
// 4 steps and clears the wrap-around file. The board it predicts waits in an
// in-order queue. Each result taken on the output stream is compared with
// the oldest waiting board. Mismatches and unexpected results are counted
// and handed to the top. The number of boards still waiting goes with them.
// ----------------------------------------------------------------------------
module bdf_fill_checker import bdf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [127:0] s_axis_tdata_i,   // generators [63:0], propagators [127:64]
  input  logic [3:0]   s_axis_tuser_i,   // mode [0], direction [3:1]
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [63:0]  m_axis_tdata_i,   // filled_board [63:0]
  output int unsigned  fail_count_o,
  output int unsigned  boards_waiting_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  board_t      awaited_boards[$];
  int unsigned fail_count;
  int unsigned result_index;

  // shift a board n single steps in one compass direction
  function automatic board_t shift_squares(board_t b, dir_e d, int unsigned n);
    int unsigned step_len;
    bit          up;
    case (d)
      DIR_N:   begin step_len = 8; up = 1'b1; end
      DIR_NE:  begin step_len = 9; up = 1'b1; end
      DIR_E:   begin step_len = 1; up = 1'b1; end
      DIR_SE:  begin step_len = 7; up = 1'b0; end
      DIR_S:   begin step_len = 8; up = 1'b0; end
      DIR_SW:  begin step_len = 9; up = 1'b0; end
      DIR_W:   begin step_len = 1; up = 1'b0; end
      default: begin step_len = 7; up = 1'b1; end
    endcase
    return up ? (b << (step_len * n)) : (b >> (step_len * n));
  endfunction

  // squares a single step may land on without wrapping round the board
  function automatic board_t landing_squares(dir_e d);
    case (d)
      DIR_NE, DIR_E, DIR_SE: return ~FILE_A_MASK;
      DIR_SW, DIR_W, DIR_NW: return ~FILE_H_MASK;
      default:               return ALL_SQUARES;
    endcase
  endfunction

  // three-level prefix flood of the sources through the open squares
  function automatic board_t flood_through(board_t src, board_t open, dir_e d);
    board_t g;
    board_t p;
    g = src;
    p = open & landing_squares(d);
    g = g | (p & shift_squares(g, d, 1));
    p = p & shift_squares(p, d, 1);
    g = g | (p & shift_squares(g, d, 2));
    p = p & shift_squares(p, d, 2);
    g = g | (p & shift_squares(g, d, 4));
    return g;
  endfunction

  // board that one query should produce
  function automatic board_t expected_board(logic mode, dir_e d, board_t src, board_t open);
    if (mode == MODE_FILL) begin
      return flood_through(src, open, d);
    end
    return shift_squares(flood_through(src, ALL_SQUARES, d), d, 1) & landing_squares(d);
  endfunction

  initial begin
    fail_count   = 0;
    result_index = 0;
  end

  // predict on each taken query, compare on each taken result
  always @(posedge clk_i) begin
    board_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        awaited_boards.push_back(expected_board(s_axis_tuser_i[0],
                                                dir_e'(s_axis_tuser_i[3:1]),
                                                s_axis_tdata_i[63:0],
                                                s_axis_tdata_i[127:64]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (awaited_boards.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected result %0d: filled_board %h with nothing awaited",
                     result_index, m_axis_tdata_i);
          end
        end else begin
          want = awaited_boards.pop_front();
          if (m_axis_tdata_i !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("result %0d: filled_board expected %h actual %h",
                       result_index, want, m_axis_tdata_i);
            end
          end
        end
        result_index++;
      end
      fail_count_o     <= fail_count;
      boards_waiting_o <= awaited_boards.size();
    end
  end

endmodule

[tb/bitboard_directional_fill_tb.sv]
// ----------------------------------------------------------------------------
// bitboard_directional_fill_tb
// stimulus and verdict for the directional bitboard fill
// ----------------------------------------------------------------------------
// A short directed set covers every direction in both modes. It takes in the
// board edges, empty and full generator sets, generators off the propagator
// set and a blocked first step. Random queries of mixed density follow. The
// sender works in bursts and the receiver stalls on changing patterns, with
// one long hold-off and pauses that let the block drain. The checker
// instance predicts and compares every result.
// ----------------------------------------------------------------------------
module bitboard_directional_fill_tb import bdf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_QUERIES = 1530;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned HOLD_OFF_AT    = 400;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned PAUSE_AT       = 800;

  typedef struct {
    logic   mode;
    dir_e   dir;
    board_t gens;
    board_t props;
  } query_t;

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;

  int unsigned  fail_count;
  int unsigned  boards_waiting;
  int unsigned  queries_sent;
  int unsigned  cycle_count;
  int unsigned  burst_left;
  bit           valid_scheduled;

  bitboard_directional_fill DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bdf_fill_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .s_axis_tuser_i   (s_tuser),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .fail_count_o     (fail_count),
    .boards_waiting_o (boards_waiting)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("bitboard_directional_fill_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic board_t rand_board();
    return {$urandom, $urandom};
  endfunction

  function automatic board_t square(int unsigned idx);
    return board_t'(1) << idx;
  endfunction

  // random query of mixed density
  function automatic query_t random_query();
    query_t q;
    q.mode = $urandom_range(0, 1) ? MODE_SPAN : MODE_FILL;
    q.dir  = dir_e'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1:    q.gens = square($urandom_range(0, 63));
      2, 3:    q.gens = square($urandom_range(0, 63)) | square($urandom_range(0, 63))
                        | square($urandom_range(0, 63));
      4, 5:    q.gens = rand_board() & rand_board() & rand_board();
      6, 7:    q.gens = rand_board();
      8:       q.gens = rand_board() & rand_board();
      default: q.gens = $urandom_range(0, 1) ? ALL_SQUARES : '0;
    endcase
    case ($urandom_range(0, 7))
      0:       q.props = ALL_SQUARES;
      1, 2:    q.props = rand_board();
      3, 4:    q.props = rand_board() | rand_board();
      5, 6:    q.props = rand_board() | rand_board() | rand_board();
      default: q.props = (rand_board() | rand_board()) & ~q.gens;
    endcase
    return q;
  endfunction

  // offer one query and hold it until taken, then idle if the burst ends
  task automatic offer(query_t q);
    s_tvalid <= 1'b1;
    valid_scheduled = 1'b1;
    s_tdata  <= {q.props, q.gens};
    s_tuser  <= {q.dir, q.mode};
    do @(posedge clk); while (!s_tready);
    queries_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      valid_scheduled = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
  endtask

  // stop offering and let every awaited result come back
  task automatic drain();
    if (valid_scheduled) begin
      s_tvalid <= 1'b0;
      valid_scheduled = 1'b0;
    end
    // the waiting count is a registered copy of the queue size, so it lags an item taken at this edge
    @(posedge clk);
    wait (boards_waiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: changing stall patterns with one long hold-off
  initial begin
    int unsigned phase;
    int unsigned phase_left;
    int unsigned hold_left;
    bit          held_off;
    bit          toggle;
    phase      = 0;
    phase_left = 0;
    hold_left  = 0;
    held_off   = 1'b0;
    toggle     = 1'b0;
    m_tready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && queries_sent >= HOLD_OFF_AT) begin
        held_off  = 1'b1;
        hold_left = HOLD_OFF_LEN;
      end
      if (phase_left == 0) begin
        phase      = $urandom_range(0, 4);
        phase_left = $urandom_range(50, 200);
      end
      phase_left--;
      toggle = ~toggle;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (phase)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= ($urandom_range(0, 9) != 0);
          3:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= toggle;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    query_t q;
    queries_sent    = 0;
    burst_left      = $urandom_range(1, 24);
    valid_scheduled = 1'b0;
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // generator on d4 not in the propagators, every direction, fill
    for (int k = 0; k < 8; k++) begin
      q = '{MODE_FILL, dir_e'(k[2:0]), square(27), ALL_SQUARES & ~square(27)};
      offer(q);
    end
    // corner generators run to the board edge, every direction, span
    for (int k = 0; k < 8; k++) begin
      q = '{MODE_SPAN, dir_e'(k[2:0]), square(0) | square(7) | square(56) | square(63),
            rand_board()};
      offer(q);
    end
    // empty generators
    offer('{MODE_FILL, DIR_N, '0, ALL_SQUARES});
    offer('{MODE_SPAN, DIR_W, '0, ALL_SQUARES});
    // first step blocked: e5 missing from the propagators
    offer('{MODE_FILL, DIR_NE, square(27), ALL_SQUARES & ~square(36)});
    // every square a generator
    offer('{MODE_FILL, DIR_E, ALL_SQUARES, '0});
    offer('{MODE_SPAN, DIR_SE, ALL_SQUARES, ALL_SQUARES});
    drain();

    // random queries
    for (int unsigned n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == PAUSE_AT) begin
        drain();
      end
      offer(random_query());
    end
    drain();

    if (fail_count == 0 && boards_waiting == 0) begin
      $display("bitboard_directional_fill_tb: PASS");
    end else begin
      $display("bitboard_directional_fill_tb: FAIL");
    end
    $finish;
  end

endmodule
